// ===== rtl/core/limit_order_book_matcher_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the order book matcher
// Property wrappers, clocked on i_clk, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define LOBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LOBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lobm_pkg.sv =====
// ---------------------------------------------------------------------------
// lobm_pkg
// Types, sizes and helpers shared by the order book matcher modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lobm_pkg;

    localparam int PRICE_LEVELS = 1024;
    localparam int ORDER_SLOTS  = 1024;

    localparam int TICK_W = $clog2(PRICE_LEVELS);
    localparam int SLOT_W = $clog2(ORDER_SLOTS);
    localparam int QTY_W  = 32;
    localparam int ID_W   = 64;

    // bitmaps for free slots and occupied levels share one index space
    localparam int BMP_BITS  = PRICE_LEVELS;
    localparam int BMP_W     = $clog2(BMP_BITS);
    localparam int CELL_BITS = 32;
    localparam int BIT_W     = $clog2(CELL_BITS);
    localparam int NUM_CELLS = BMP_BITS / CELL_BITS;
    localparam int CELL_W    = BMP_W - BIT_W;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 128;

    typedef enum logic [1:0] {
        SEL_FREE = 2'd0,
        SEL_BID  = 2'd1,
        SEL_ASK  = 2'd2
    } t_sel;

    // search token walking the cell chain
    typedef struct packed {
        logic             valid;
        t_sel             sel;
        logic [BMP_W-1:0] start;
        logic             found;
        logic [BMP_W-1:0] idx;
    } t_tok;

    // single-bit bitmap write
    typedef struct packed {
        logic             en;
        t_sel             sel;
        logic [BMP_W-1:0] idx;
        logic             val;
    } t_wr;

    function automatic logic [BIT_W-1:0] lowest_bit(input logic [CELL_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = CELL_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    // bids are kept mirrored so a descending tick walk is an ascending search
    function automatic logic [TICK_W-1:0] mirror_tick(input logic [TICK_W-1:0] t);
        return TICK_W'(PRICE_LEVELS - 1) - t;
    endfunction

endpackage

// ===== rtl/core/lobm_cell.sv =====
// ---------------------------------------------------------------------------
// lobm_cell
// One chain cell: a slice of the free, bid and ask bitmaps plus a search stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lobm_pkg::CELL_W-1:0] i_cell_idx,
    input  lobm_pkg::t_tok            i_tok,
    input  lobm_pkg::t_wr             i_wr,
    output lobm_pkg::t_tok            o_tok
);
    import lobm_pkg::*;

    logic [CELL_BITS-1:0] r_free;
    logic [CELL_BITS-1:0] r_bid;
    logic [CELL_BITS-1:0] r_ask;
    t_tok                 r_tok;
    t_tok                 n_tok;

    logic [CELL_BITS-1:0] word;
    logic [CELL_BITS-1:0] mask;
    logic [CELL_BITS-1:0] hits;
    logic [CELL_W-1:0]    start_cell;

    always_comb begin
        case (i_tok.sel)
            SEL_FREE: word = r_free;
            SEL_BID:  word = r_bid;
            SEL_ASK:  word = r_ask;
            default:  word = '0;
        endcase
        start_cell = i_tok.start[BMP_W-1:BIT_W];
        if (start_cell == i_cell_idx) begin
            mask = {CELL_BITS{1'b1}} << i_tok.start[BIT_W-1:0];
        end else if (start_cell < i_cell_idx) begin
            mask = '1;
        end else begin
            mask = '0;
        end
        hits  = word & mask;
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.found && (|hits)) begin
            n_tok.found = 1'b1;
            n_tok.idx   = {i_cell_idx, lowest_bit(hits)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_bid  <= '0;
            r_ask  <= '0;
            r_tok  <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && (i_wr.idx[BMP_W-1:BIT_W] == i_cell_idx)) begin
                case (i_wr.sel)
                    SEL_FREE: r_free[i_wr.idx[BIT_W-1:0]] <= i_wr.val;
                    SEL_BID:  r_bid[i_wr.idx[BIT_W-1:0]]  <= i_wr.val;
                    SEL_ASK:  r_ask[i_wr.idx[BIT_W-1:0]]  <= i_wr.val;
                    default: ;
                endcase
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/lobm_seq.sv =====
// ---------------------------------------------------------------------------
// lobm_seq
// Match sequencer: slot and level memories, walk control, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobm_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lobm_pkg::TICK_W-1:0] i_price_tick,
    input  logic [lobm_pkg::QTY_W-1:0]  i_quantity,
    input  logic                        i_side,
    input  logic [lobm_pkg::ID_W-1:0]   i_client_id,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lobm_pkg::ID_W-1:0]   o_echo_id,
    output logic [lobm_pkg::QTY_W-1:0]  o_filled_qty,
    output logic [lobm_pkg::QTY_W-1:0]  o_rested_qty,
    output logic                        o_status,
    output lobm_pkg::t_tok              o_tok,
    input  lobm_pkg::t_tok              i_tok,
    output lobm_pkg::t_wr               o_wr
);
    import lobm_pkg::*;

    `include "limit_order_book_matcher_unit_macros.svh"

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LWAIT = 9'b000000010,
        S_HEAD  = 9'b000000100,
        S_SLOT  = 9'b000001000,
        S_OCC   = 9'b000010000,
        S_FWAIT = 9'b000100000,
        S_PWAIT = 9'b001000000,
        S_TAIL  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [TICK_W-1:0]  r_p, n_p;
    logic [QTY_W-1:0]   r_rem, n_rem;
    logic               r_sell, n_sell;
    logic [ID_W-1:0]    r_id, n_id;
    logic [QTY_W-1:0]   r_filled, n_filled;
    logic [QTY_W-1:0]   r_rested, n_rested;
    logic               r_status, n_status;
    logic [TICK_W-1:0]  r_t, n_t;
    logic [BMP_W-1:0]   r_lidx, n_lidx;
    logic [SLOT_W-1:0]  r_s, n_s;
    t_tok               r_tok, n_tok;
    logic               r_ovalid;
    logic [ID_W-1:0]    r_oid;
    logic [QTY_W-1:0]   r_ofill, r_orest;
    logic               r_ostat;
    logic               load_out;

    // memories
    logic [QTY_W-1:0]  mem_qty   [ORDER_SLOTS];
    logic [ID_W-1:0]   mem_ident [ORDER_SLOTS];
    logic [SLOT_W-1:0] mem_next  [ORDER_SLOTS];
    logic [SLOT_W-1:0] mem_bhead [PRICE_LEVELS];
    logic [SLOT_W-1:0] mem_btail [PRICE_LEVELS];
    logic [SLOT_W-1:0] mem_ahead [PRICE_LEVELS];
    logic [SLOT_W-1:0] mem_atail [PRICE_LEVELS];

    logic [SLOT_W-1:0] slot_ra, lvl_ra;
    logic [QTY_W-1:0]  qty_q;
    logic [SLOT_W-1:0] next_q, bhead_q, btail_q, ahead_q, atail_q;

    logic              qty_we, ident_we, next_we;
    logic [SLOT_W-1:0] qty_wa, ident_wa, next_wa;
    logic [QTY_W-1:0]  qty_wd;
    logic [SLOT_W-1:0] next_wd;
    logic              bhead_we, btail_we, ahead_we, atail_we;
    logic [TICK_W-1:0] lvl_wa;
    logic [SLOT_W-1:0] head_wd, tail_wd;

    logic [SLOT_W-1:0] walk_head, walk_tail, rest_tail;
    logic [TICK_W-1:0] t_cand;
    logic              lvl_ok;
    logic [QTY_W-1:0]  take;
    logic [QTY_W-1:0]  new_q;

    always_ff @(posedge i_clk) begin
        if (qty_we) mem_qty[qty_wa] <= qty_wd;
        qty_q <= mem_qty[slot_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ident_we) mem_ident[ident_wa] <= r_id;
    end
    always_ff @(posedge i_clk) begin
        if (next_we) mem_next[next_wa] <= next_wd;
        next_q <= mem_next[slot_ra];
    end
    always_ff @(posedge i_clk) begin
        if (bhead_we) mem_bhead[lvl_wa] <= head_wd;
        bhead_q <= mem_bhead[lvl_ra];
    end
    always_ff @(posedge i_clk) begin
        if (btail_we) mem_btail[lvl_wa] <= tail_wd;
        btail_q <= mem_btail[lvl_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ahead_we) mem_ahead[lvl_wa] <= head_wd;
        ahead_q <= mem_ahead[lvl_ra];
    end
    always_ff @(posedge i_clk) begin
        if (atail_we) mem_atail[lvl_wa] <= tail_wd;
        atail_q <= mem_atail[lvl_ra];
    end

    // a sell walks bids, a buy walks asks; the remainder rests on its own side
    assign walk_head = r_sell ? bhead_q : ahead_q;
    assign walk_tail = r_sell ? btail_q : atail_q;
    assign rest_tail = r_sell ? atail_q : btail_q;

    assign t_cand = r_sell ? mirror_tick(i_tok.idx) : i_tok.idx;
    assign lvl_ok = i_tok.found && (r_sell ? (t_cand >= r_p) : (t_cand <= r_p));
    assign take   = (qty_q < r_rem) ? qty_q : r_rem;
    assign new_q  = qty_q - take;

    assign o_in_ready = (r_state == S_IDLE);
    assign load_out   = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_rem    = r_rem;
        n_sell   = r_sell;
        n_id     = r_id;
        n_filled = r_filled;
        n_rested = r_rested;
        n_status = r_status;
        n_t      = r_t;
        n_lidx   = r_lidx;
        n_s      = r_s;
        n_tok    = '0;
        slot_ra  = r_s;
        lvl_ra   = r_t;
        qty_we   = 1'b0;
        qty_wa   = r_s;
        qty_wd   = new_q;
        ident_we = 1'b0;
        ident_wa = r_s;
        next_we  = 1'b0;
        next_wa  = rest_tail;
        next_wd  = r_s;
        bhead_we = 1'b0;
        btail_we = 1'b0;
        ahead_we = 1'b0;
        atail_we = 1'b0;
        lvl_wa   = r_t;
        head_wd  = r_s;
        tail_wd  = r_s;
        o_wr     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_p      = (32'(i_price_tick) >= PRICE_LEVELS) ?
                               TICK_W'(PRICE_LEVELS - 1) : i_price_tick;
                    n_rem    = i_quantity;
                    n_sell   = i_side;
                    n_id     = i_client_id;
                    n_filled = '0;
                    n_rested = '0;
                    n_status = 1'b0;
                    if (i_quantity == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_tok.valid = 1'b1;
                        n_tok.sel   = i_side ? SEL_BID : SEL_ASK;
                        n_tok.start = '0;
                        n_state     = S_LWAIT;
                    end
                end
            end
            S_LWAIT: begin
                if (i_tok.valid) begin
                    if (lvl_ok) begin
                        n_t     = t_cand;
                        n_lidx  = i_tok.idx;
                        lvl_ra  = t_cand;
                        n_state = S_HEAD;
                    end else begin
                        n_tok.valid = 1'b1;
                        n_tok.sel   = SEL_FREE;
                        n_tok.start = '0;
                        n_state     = S_FWAIT;
                    end
                end
            end
            S_HEAD: begin
                n_s     = walk_head;
                slot_ra = walk_head;
                n_state = S_SLOT;
            end
            S_SLOT: begin
                qty_we   = 1'b1;
                n_rem    = r_rem - take;
                n_filled = r_filled + take;
                if (new_q != '0) begin
                    n_state = S_DONE;
                end else begin
                    o_wr.en  = 1'b1;
                    o_wr.sel = SEL_FREE;
                    o_wr.idx = r_s;
                    o_wr.val = 1'b1;
                    if (r_s == walk_tail) begin
                        n_state = S_OCC;
                    end else begin
                        // level keeps orders: advance its head
                        head_wd  = next_q;
                        bhead_we = r_sell;
                        ahead_we = !r_sell;
                        if (n_rem == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_s     = next_q;
                            slot_ra = next_q;
                        end
                    end
                end
            end
            S_OCC: begin
                o_wr.en  = 1'b1;
                o_wr.sel = r_sell ? SEL_BID : SEL_ASK;
                o_wr.idx = r_lidx;
                o_wr.val = 1'b0;
                if (r_rem == '0) begin
                    n_state = S_DONE;
                end else if (r_lidx == BMP_W'(BMP_BITS - 1)) begin
                    n_tok.valid = 1'b1;
                    n_tok.sel   = SEL_FREE;
                    n_tok.start = '0;
                    n_state     = S_FWAIT;
                end else begin
                    n_tok.valid = 1'b1;
                    n_tok.sel   = r_sell ? SEL_BID : SEL_ASK;
                    n_tok.start = r_lidx + BMP_W'(1);
                    n_state     = S_LWAIT;
                end
            end
            S_FWAIT: begin
                if (i_tok.valid) begin
                    if (!i_tok.found) begin
                        n_status = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_s      = i_tok.idx;
                        o_wr.en  = 1'b1;
                        o_wr.sel = SEL_FREE;
                        o_wr.idx = i_tok.idx;
                        o_wr.val = 1'b0;
                        qty_we   = 1'b1;
                        qty_wa   = i_tok.idx;
                        qty_wd   = r_rem;
                        ident_we = 1'b1;
                        ident_wa = i_tok.idx;
                        // probe occupancy of the resting level
                        n_lidx      = r_sell ? r_p : mirror_tick(r_p);
                        n_tok.valid = 1'b1;
                        n_tok.sel   = r_sell ? SEL_ASK : SEL_BID;
                        n_tok.start = r_sell ? r_p : mirror_tick(r_p);
                        n_state     = S_PWAIT;
                    end
                end
            end
            S_PWAIT: begin
                lvl_ra = r_p;
                if (i_tok.valid) begin
                    if (i_tok.found && (i_tok.idx == r_lidx)) begin
                        n_state = S_TAIL;
                    end else begin
                        lvl_wa   = r_p;
                        bhead_we = !r_sell;
                        btail_we = !r_sell;
                        ahead_we = r_sell;
                        atail_we = r_sell;
                        o_wr.en  = 1'b1;
                        o_wr.sel = r_sell ? SEL_ASK : SEL_BID;
                        o_wr.idx = r_lidx;
                        o_wr.val = 1'b1;
                        n_rested = r_rem;
                        n_state  = S_DONE;
                    end
                end
            end
            S_TAIL: begin
                lvl_ra   = r_p;
                lvl_wa   = r_p;
                next_we  = 1'b1;
                btail_we = !r_sell;
                atail_we = r_sell;
                n_rested = r_rem;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tok    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tok   <= n_tok;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_rem    <= n_rem;
        r_sell   <= n_sell;
        r_id     <= n_id;
        r_filled <= n_filled;
        r_rested <= n_rested;
        r_status <= n_status;
        r_t      <= n_t;
        r_lidx   <= n_lidx;
        r_s      <= n_s;
        if (load_out) begin
            r_oid   <= r_id;
            r_ofill <= r_filled;
            r_orest <= r_rested;
            r_ostat <= r_status;
        end
    end

    assign o_tok        = r_tok;
    assign o_out_valid  = r_ovalid;
    assign o_echo_id    = r_oid;
    assign o_filled_qty = r_ofill;
    assign o_rested_qty = r_orest;
    assign o_status     = r_ostat;

    `LOBM_ASSERT_IMP(a_tok_when_waiting, i_tok.valid,
        (r_state == S_LWAIT) || (r_state == S_FWAIT) || (r_state == S_PWAIT))
    `LOBM_ASSERT_IMP(a_slot_has_rem, r_state == S_SLOT, r_rem != '0)
    `LOBM_ASSERT_IMP(a_reject_rests_none, (r_state == S_DONE) && r_status, r_rested == '0)
    `LOBM_ASSERT_NXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state != S_IDLE)

endmodule

// ===== rtl/core/limit_order_book_matcher_unit.sv =====
// Sequence: a zero quantity goes from idle straight to the done state. Otherwise each price
// level visited takes a scan through the token register and the cell chain, a head read and
// a level clear, each resting order filled takes a slot update, and resting a remainder takes
// a free-slot scan, a level probe and a tail link (no tail link when its level was empty).
// Throughput: one order at a time; the next word is taken once the sequencer is idle, while
// a finished result may still wait in the output register.
// ---------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority limit order book with bitmap scan chain and link memories.
// Reset: synchronous; all slots free and all levels empty, no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module limit_order_book_matcher_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] price_tick, [41:10] quantity, [105:42] client_id, rest zero
    input  logic [lobm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] side
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [63:0] echo_id, [95:64] filled_qty, [127:96] rested_qty
    output logic [lobm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] status
    output logic                              m_axis_tuser
);
    import lobm_pkg::*;

    t_tok tok [NUM_CELLS+1];
    t_wr  wr;

    logic [ID_W-1:0]  echo_id;
    logic [QTY_W-1:0] filled_qty, rested_qty;

    lobm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_price_tick (s_axis_tdata[TICK_W-1:0]),
        .i_quantity   (s_axis_tdata[TICK_W+QTY_W-1:TICK_W]),
        .i_side       (s_axis_tuser),
        .i_client_id  (s_axis_tdata[TICK_W+QTY_W+ID_W-1:TICK_W+QTY_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_echo_id    (echo_id),
        .o_filled_qty (filled_qty),
        .o_rested_qty (rested_qty),
        .o_status     (m_axis_tuser),
        .o_tok        (tok[0]),
        .i_tok        (tok[NUM_CELLS]),
        .o_wr         (wr)
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        lobm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (CELL_W'(g)),
            .i_tok      (tok[g]),
            .i_wr       (wr),
            .o_tok      (tok[g+1])
        );
    end

    assign m_axis_tdata = {rested_qty, filled_qty, echo_id};

endmodule
